@@ hw/rtl/pts_reorder_buffer_macros.svh @@
// Assertion macros shared by the checker
`ifndef PTS_REORDER_BUFFER_MACROS_SVH
`define PTS_REORDER_BUFFER_MACROS_SVH

// Same-cycle implication
`define PTSRB_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication
`define PTSRB_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/ptsrb_pkg.sv @@
package ptsrb_pkg;

	localparam int TAG_W = 16;
	localparam int PTS_W = 63;
	localparam int THR_W = 5;
	localparam int CFG_W = 14;
	localparam int CFG_IDX_W = 3;
	localparam int DPB_W = 18;
	localparam int MB_W = 11;
	localparam int MBS_W = 22;
	localparam int IN_DATA_W = 88;
	localparam int OUT_DATA_W = 80;
	localparam logic [7:0] BASELINE_PROFILE = 8'd66;

	typedef enum logic [1:0] {
		OP_SUBMIT = 2'd0,
		OP_DECODED = 2'd1,
		OP_DRAIN = 2'd2,
		OP_FLUSH = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		DISP_OUTPUT = 2'd0,
		DISP_DROPPED = 2'd1,
		DISP_NOT_NEG = 2'd2
	} disp_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IS_H264 = 3'd0,
		REG_PROFILE = 3'd1,
		REG_LEVEL = 3'd2,
		REG_WIDTH = 3'd3,
		REG_HEIGHT = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_INSERT,
		ST_EMIT1,
		ST_POP
	} state_t;

	typedef struct packed {
		logic load_in;
		logic insert;
		logic emit_single;
		logic pop;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic negotiated;
		logic decode_ok;
		logic full;
		logic pop_go;
		logic pop_more;
		logic out_free;
		logic thr_busy;
	} dp_status_t;

	// Maximum decoded picture buffer size in macroblocks per level
	function automatic logic [DPB_W-1:0] dpb_macroblocks(input logic [7:0] level);
		logic [DPB_W-1:0] r;
		case (level)
			8'd10: r = 18'd396;
			8'd11: r = 18'd900;
			8'd12, 8'd13, 8'd20: r = 18'd2376;
			8'd21: r = 18'd4752;
			8'd22, 8'd30: r = 18'd8100;
			8'd31: r = 18'd18000;
			8'd32: r = 18'd20480;
			8'd40, 8'd41: r = 18'd32768;
			8'd42: r = 18'd34816;
			8'd50: r = 18'd110400;
			8'd51, 8'd52: r = 18'd184320;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/ptsrb_thresh.sv @@
module ptsrb_thresh #(
	parameter int MAX_REORDER = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ptsrb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ptsrb_pkg::CFG_W-1:0] cfg_wdata,
	output logic [ptsrb_pkg::THR_W-1:0] thr,
	output logic negotiated,
	output logic busy
);
	import ptsrb_pkg::*;

	localparam logic [2:0] DIV_LAST = 3'd5;
	localparam logic [2:0] FINISH = 3'd6;

	logic is_h264_q;
	logic [7:0] profile_q, level_q;
	logic [CFG_W-1:0] width_q, height_q;
	logic busy_q;
	logic [2:0] cnt_q;
	logic [MBS_W-1:0] mbs_q;
	logic [DPB_W-1:0] rem_q;
	logic [THR_W-1:0] quo_q, thr_q;
	logic neg_q;

	logic [MB_W-1:0] wmb, hmb;
	logic [DPB_W-1:0] dpb;
	logic [2:0] k;
	logic [MBS_W+3:0] sh;
	logic fits;

	assign wmb = MB_W'((15'(width_q) + 15'd15) >> 4);
	assign hmb = MB_W'((15'(height_q) + 15'd15) >> 4);
	assign dpb = dpb_macroblocks(level_q);
	assign k = DIV_LAST - cnt_q;
	assign sh = (MBS_W+4)'(mbs_q) << k;
	assign fits = (MBS_W+4)'(rem_q) >= sh;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_h264_q <= 1'b1;
			profile_q <= 8'd100;
			level_q <= 8'd40;
			width_q <= 14'd1920;
			height_q <= 14'd1088;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IS_H264: is_h264_q <= cfg_wdata[0];
				REG_PROFILE: profile_q <= cfg_wdata[7:0];
				REG_LEVEL: level_q <= cfg_wdata[7:0];
				REG_WIDTH: width_q <= cfg_wdata;
				REG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Multiply, then restoring divide one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
			thr_q <= '0;
			neg_q <= 1'b1;
		end else if (cfg_we && cfg_index <= REG_HEIGHT) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == FINISH) begin
				busy_q <= 1'b0;
				thr_q <= '0;
				neg_q <= 1'b1;
				if (is_h264_q) begin
					if (width_q == '0 || height_q == '0) begin
						neg_q <= 1'b0;
					end else if (profile_q != BASELINE_PROFILE) begin
						if (dpb == '0) begin
							neg_q <= 1'b0;
						end else if (quo_q >= THR_W'(MAX_REORDER)) begin
							thr_q <= THR_W'(MAX_REORDER);
						end else begin
							thr_q <= quo_q;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && cnt_q == '0) begin
			mbs_q <= MBS_W'(wmb) * MBS_W'(hmb);
			rem_q <= dpb;
			quo_q <= '0;
		end else if (busy_q && cnt_q <= DIV_LAST && fits) begin
			rem_q <= rem_q - DPB_W'(sh);
			quo_q[k] <= 1'b1;
		end
	end

	assign thr = thr_q;
	assign negotiated = neg_q;
	assign busy = busy_q;

endmodule

@@ hw/rtl/ptsrb_datapath.sv @@
module ptsrb_datapath #(
	parameter int QUEUE_DEPTH = 32,
	parameter int MAX_REORDER = 16
) (
	input logic clk,
	input logic arst_n,
	input ptsrb_pkg::dp_cmd_t cmd,
	output ptsrb_pkg::dp_status_t status,
	input logic [ptsrb_pkg::IN_DATA_W-1:0] s_tdata,
	input logic [1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	output logic [ptsrb_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic m_tlast,
	input logic cfg_we,
	input logic [ptsrb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ptsrb_pkg::CFG_W-1:0] cfg_wdata
);
	import ptsrb_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	opcode_t op_q;
	logic [TAG_W-1:0] tag_q;
	logic [PTS_W-1:0] pts_q;
	logic pv_q, ok_q;

	logic [TAG_W-1:0] e_tag_q [QUEUE_DEPTH];
	logic [PTS_W-1:0] e_pts_q [QUEUE_DEPTH];
	logic e_pv_q [QUEUE_DEPTH];
	logic [CW-1:0] count_q;
	logic [QUEUE_DEPTH-1:0] mask_q, after;

	logic out_valid_q, out_last_q, out_pv_q;
	logic [TAG_W-1:0] out_tag_q;
	logic [PTS_W-1:0] out_pts_q;
	disp_t out_disp_q;

	logic [THR_W-1:0] thr;
	logic negotiated, thr_busy;
	logic [CW-1:0] count_m1;

	ptsrb_thresh #(.MAX_REORDER(MAX_REORDER)) u_thresh (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .thr(thr), .negotiated(negotiated), .busy(thr_busy)
	);

	// Latch the accepted word
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= opcode_t'(s_tuser);
			tag_q <= s_tdata[15:0];
			pts_q <= s_tdata[78:16];
			pv_q <= s_tdata[79];
			ok_q <= s_tdata[80];
		end
	end

	// Flag occupied entries whose valid pts is later than the new one
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			mask_q[i] <= pv_q && e_pv_q[i] && (e_pts_q[i] > pts_q) && (CW'(i) < count_q);
		end
	end

	// Positions at or past the first later entry
	assign after = mask_q | (~mask_q + QUEUE_DEPTH'(1));

	// Shift cells up on insert, down on pop
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (cmd.insert) begin
				if ((after[i] && (i == 0 || !after[(i == 0) ? 0 : i-1]))
						|| (mask_q == '0 && CW'(i) == count_q)) begin
					e_tag_q[i] <= tag_q;
					e_pts_q[i] <= pts_q;
					e_pv_q[i] <= pv_q;
				end else if (after[i] && i > 0) begin
					e_tag_q[i] <= e_tag_q[(i == 0) ? 0 : i-1];
					e_pts_q[i] <= e_pts_q[(i == 0) ? 0 : i-1];
					e_pv_q[i] <= e_pv_q[(i == 0) ? 0 : i-1];
				end
			end else if (cmd.pop && i < QUEUE_DEPTH-1) begin
				e_tag_q[i] <= e_tag_q[(i < QUEUE_DEPTH-1) ? i+1 : i];
				e_pts_q[i] <= e_pts_q[(i < QUEUE_DEPTH-1) ? i+1 : i];
				e_pv_q[i] <= e_pv_q[(i < QUEUE_DEPTH-1) ? i+1 : i];
			end
		end
	end

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= count_m1;
		end
	end

	assign count_m1 = count_q - CW'(1);

	// Load the output register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop || cmd.emit_single) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_tag_q <= e_tag_q[0];
			out_pts_q <= e_pts_q[0];
			out_pv_q <= e_pv_q[0];
			out_disp_q <= (op_q == OP_FLUSH) ? DISP_DROPPED : DISP_OUTPUT;
			out_last_q <= !status.pop_more;
		end else if (cmd.emit_single) begin
			out_tag_q <= tag_q;
			out_last_q <= 1'b1;
			if (op_q == OP_SUBMIT) begin
				out_pts_q <= '0;
				out_pv_q <= 1'b0;
				out_disp_q <= DISP_NOT_NEG;
			end else begin
				out_pts_q <= pts_q;
				out_pv_q <= pv_q;
				out_disp_q <= DISP_DROPPED;
			end
		end
	end

	// Report status to the controller
	always_comb begin
		status.op = op_q;
		status.negotiated = negotiated;
		status.decode_ok = ok_q;
		status.full = count_q == CW'(QUEUE_DEPTH);
		status.pop_go = (count_q != '0) && (op_q != OP_SUBMIT || count_q >= CW'(thr));
		status.pop_more = (count_q > CW'(1))
			&& (op_q != OP_SUBMIT || count_m1 >= CW'(thr));
		status.out_free = !out_valid_q || m_tready;
		status.thr_busy = thr_busy;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_pv_q, out_pts_q, out_tag_q};
	assign m_tuser = out_disp_q;
	assign m_tlast = out_last_q;

endmodule

@@ hw/rtl/ptsrb_ctrl.sv @@
module ptsrb_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input ptsrb_pkg::dp_status_t status,
	output ptsrb_pkg::dp_cmd_t cmd
);
	import ptsrb_pkg::*;

	state_t state_q, state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence one word at a time
	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = !status.thr_busy;
				if (s_tvalid && !status.thr_busy) begin
					cmd.load_in = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				case (status.op)
					OP_SUBMIT: state_d = status.negotiated ? ST_POP : ST_EMIT1;
					OP_DECODED: state_d = (!status.decode_ok || status.full)
						? ST_EMIT1 : ST_INSERT;
					default: state_d = ST_POP;
				endcase
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d = ST_IDLE;
			end
			ST_EMIT1: begin
				if (status.out_free) begin
					cmd.emit_single = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				if (!status.pop_go) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.pop = 1'b1;
					if (!status.pop_more) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/pts_reorder_buffer.sv @@
// Presentation-time reorder queue for decoded frames.
// Input stream: tuser carries the opcode (submit, decoded frame, drain,
// flush); tdata carries the frame tag, pts, pts valid and decode status.
// Output stream: one word per released, dropped or rejected frame, tuser holding
// the disposition and tlast marking the final word caused by an input.
// Configuration: write cfg_index/cfg_wdata with cfg_we high while idle;
// each write to an index up to REG_HEIGHT reruns the release threshold unit, which
// steps through one multiply, five divide steps and one finish, and holds s_tready low.
// Sequencing: an input is taken in ST_IDLE and evaluated in ST_EVAL;
// a decoded frame is inserted in the cycle after, and no new input is taken
// until the controller is back in ST_IDLE; a single drop or reject word is loaded
// from ST_EMIT1, and a release burst from ST_POP delivers one word per cycle while the receiver takes them.
// The queue is a row of shift cells, so insert and head pop each move all
// cells at once. After reset the queue is empty and the threshold unit
// runs once on the reset configuration before the first input is taken.
// A stalled receiver holds the output register; the burst waits on it.
module pts_reorder_buffer #(
	parameter int QUEUE_DEPTH = 32,
	parameter int MAX_REORDER = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [ptsrb_pkg::IN_DATA_W-1:0] s_tdata, // frame_tag, pts, pts_valid, decode_ok
	input logic [1:0] s_tuser, // opcode
	output logic m_tvalid,
	input logic m_tready,
	output logic [ptsrb_pkg::OUT_DATA_W-1:0] m_tdata, // out_tag, out_pts, out_pts_valid
	output logic [1:0] m_tuser, // disposition
	output logic m_tlast,
	input logic cfg_we,
	input logic [ptsrb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ptsrb_pkg::CFG_W-1:0] cfg_wdata
);
	import ptsrb_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;

	ptsrb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.status(status), .cmd(cmd)
	);

	ptsrb_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_REORDER(MAX_REORDER)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

endmodule

@@ hw/rtl/ptsrb_checker.sv @@
`include "pts_reorder_buffer_macros.svh"

module ptsrb_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [ptsrb_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic m_tlast
);
	import ptsrb_pkg::*;

	// Output word holds while stalled
	`PTSRB_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// No new word is taken in the cycle after one is taken
	`PTSRB_ASSERT_NXT(a_one_word, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// Disposition is a known code
	`PTSRB_ASSERT_IMP(a_disp, clk, arst_n, m_tvalid, m_tuser == DISP_OUTPUT || m_tuser == DISP_DROPPED || m_tuser == DISP_NOT_NEG)
	// A reject word stands alone with no timestamp
	`PTSRB_ASSERT_IMP(a_reject, clk, arst_n, m_tvalid && m_tuser == DISP_NOT_NEG, m_tlast && m_tdata[79:16] == '0)

endmodule

bind pts_reorder_buffer ptsrb_checker u_ptsrb_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tuser(m_tuser), .m_tlast(m_tlast)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import ptsrb_pkg::*;

	localparam int DEPTH = 32;
	localparam int REORDER_CAP = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		opcode_t op;
		logic [TAG_W-1:0] tag;
		logic [PTS_W-1:0] pts;
		logic pv;
		logic ok;
	} frame_cmd_t;

	typedef struct {
		logic [TAG_W-1:0] tag;
		logic [PTS_W-1:0] pts;
		logic pv;
		disp_t disp;
		logic last;
	} frame_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0; // frame_tag, pts, pts_valid, decode_ok
	logic [1:0] s_tuser = '0; // opcode
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata; // out_tag, out_pts, out_pts_valid
	logic [1:0] m_tuser; // disposition
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	pts_reorder_buffer u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// shadow of the block's queue and configuration
	logic [TAG_W-1:0] q_tag [DEPTH];
	logic [PTS_W-1:0] q_pts [DEPTH];
	logic q_ok [DEPTH];
	int q_count = 0;
	int sh_thr;
	logic sh_neg;
	logic sh_h264 = 1'b1;
	logic [7:0] sh_profile = 8'd100;
	logic [7:0] sh_level = 8'd40;
	logic [13:0] sh_width = 14'd1920;
	logic [13:0] sh_height = 14'd1088;

	frame_cmd_t pending_cmds[$];
	frame_cmd_t cur_cmd;
	frame_out_t expected_frames[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int words_seen = 0;
	int cmds_taken = 0;
	int cycles = 0;
	logic hold_go = 1'b0;
	logic hold_off = 1'b0;

	function automatic int dpb_size(logic [7:0] lvl);
		case (lvl)
			8'd10: return 396;
			8'd11: return 900;
			8'd12, 8'd13, 8'd20: return 2376;
			8'd21: return 4752;
			8'd22, 8'd30: return 8100;
			8'd31: return 18000;
			8'd32: return 20480;
			8'd40, 8'd41: return 32768;
			8'd42: return 34816;
			8'd50: return 110400;
			8'd51, 8'd52: return 184320;
			default: return 0;
		endcase
	endfunction

	function automatic void update_threshold();
		int dpb;
		int mbs;
		sh_thr = 0;
		sh_neg = 1'b1;
		if (!sh_h264)
			return;
		if (sh_width == 0 || sh_height == 0) begin
			sh_neg = 1'b0;
			return;
		end
		if (sh_profile == BASELINE_PROFILE)
			return;
		dpb = dpb_size(sh_level);
		if (dpb == 0) begin
			sh_neg = 1'b0;
			return;
		end
		mbs = ((int'(sh_width) + 15) >> 4) * ((int'(sh_height) + 15) >> 4);
		sh_thr = dpb / mbs;
		if (sh_thr > REORDER_CAP)
			sh_thr = REORDER_CAP;
	endfunction

	function automatic void push_frame(logic [TAG_W-1:0] t, logic [PTS_W-1:0] p, logic v,
			disp_t d);
		frame_out_t f;
		f.tag = t;
		f.pts = p;
		f.pv = v;
		f.disp = d;
		f.last = 1'b0;
		expected_frames.push_back(f);
	endfunction

	function automatic void release_head(disp_t d);
		push_frame(q_tag[0], q_pts[0], q_ok[0], d);
		for (int i = 0; i < q_count - 1; i++) begin
			q_tag[i] = q_tag[i+1];
			q_pts[i] = q_pts[i+1];
			q_ok[i] = q_ok[i+1];
		end
		q_count--;
	endfunction

	// work out the words one accepted command causes
	function automatic void predict_frames(frame_cmd_t c);
		int start;
		int pos;
		start = expected_frames.size();
		case (c.op)
			OP_SUBMIT: begin
				if (!sh_neg)
					push_frame(c.tag, '0, 1'b0, DISP_NOT_NEG);
				else
					while (q_count > 0 && q_count >= sh_thr)
						release_head(DISP_OUTPUT);
			end
			OP_DECODED: begin
				if (!c.ok || q_count >= DEPTH) begin
					push_frame(c.tag, c.pts, c.pv, DISP_DROPPED);
				end else begin
					pos = q_count;
					if (c.pv)
						for (int i = 0; i < q_count; i++)
							if (q_ok[i] && q_pts[i] > c.pts) begin
								pos = i;
								break;
							end
					for (int i = q_count; i > pos; i--) begin
						q_tag[i] = q_tag[i-1];
						q_pts[i] = q_pts[i-1];
						q_ok[i] = q_ok[i-1];
					end
					q_tag[pos] = c.tag;
					q_pts[pos] = c.pts;
					q_ok[pos] = c.pv;
					q_count++;
				end
			end
			default: begin
				while (q_count > 0)
					release_head(c.op == OP_DRAIN ? DISP_OUTPUT : DISP_DROPPED);
			end
		endcase
		if (expected_frames.size() > start)
			expected_frames[expected_frames.size()-1].last = 1'b1;
	endfunction

	// clock and cycle limit
	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// driver: offer the next pending command, predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_frames(cur_cmd);
				cmds_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_cmd = pending_cmds.pop_front();
					s_tdata <= {7'b0, cur_cmd.ok, cur_cmd.pv, cur_cmd.pts, cur_cmd.tag};
					s_tuser <= cur_cmd.op;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each word with the oldest expectation
	always @(posedge clk) begin
		frame_out_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				words_seen++;
				if (expected_frames.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word tag=%h disp=%0d", m_tdata[15:0], m_tuser);
				end else begin
					e = expected_frames.pop_front();
					if (m_tdata[15:0] !== e.tag || m_tdata[78:16] !== e.pts ||
							m_tdata[79] !== e.pv || m_tuser !== e.disp || m_tlast !== e.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp tag=%h pts=%h v=%b d=%0d l=%b got tag=%h pts=%h v=%b d=%0d l=%b",
								e.tag, e.pts, e.pv, e.disp, e.last,
								m_tdata[15:0], m_tdata[78:16], m_tdata[79], m_tuser, m_tlast);
					end
				end
			end
			m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic [PTS_W-1:0] rand_pts();
		case ($urandom_range(3))
			0: return PTS_W'($urandom_range(15));
			1: return PTS_W'({$urandom, $urandom});
			2: return {PTS_W{1'b1}};
			default: return PTS_W'($urandom_range(1000));
		endcase
	endfunction

	task automatic add_cmd(opcode_t op, logic [TAG_W-1:0] t, logic [PTS_W-1:0] p,
			logic v, logic ok);
		frame_cmd_t c;
		c.op = op;
		c.tag = t;
		c.pts = p;
		c.pv = v;
		c.ok = ok;
		pending_cmds.push_back(c);
	endtask

	task automatic add_random(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 55)
				add_cmd(OP_DECODED, TAG_W'($urandom), rand_pts(), $urandom_range(99) < 85,
					1'b1);
			else if (r < 65)
				add_cmd(OP_DECODED, TAG_W'($urandom), rand_pts(), 1'($urandom_range(1)),
					1'b0);
			else if (r < 88)
				add_cmd(OP_SUBMIT, TAG_W'($urandom), rand_pts(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else if (r < 94)
				add_cmd(OP_DRAIN, TAG_W'($urandom), rand_pts(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else
				add_cmd(OP_FLUSH, TAG_W'($urandom), rand_pts(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
		end
	endtask

	// hold until every command is taken and every word has come back
	task automatic wait_quiet();
		while (pending_cmds.size() > 0 || s_tvalid || expected_frames.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_IS_H264: sh_h264 = val[0];
			REG_PROFILE: sh_profile = val[7:0];
			REG_LEVEL: sh_level = val[7:0];
			REG_WIDTH: sh_width = val;
			REG_HEIGHT: sh_height = val;
			default: ;
		endcase
		update_threshold();
		@(posedge clk);
		cfg_we <= 1'b0;
		// let the threshold unit finish
		repeat (10) @(posedge clk);
	endtask

	task automatic set_config(logic h, logic [13:0] prof, logic [13:0] lvl,
			logic [13:0] w, logic [13:0] ht);
		write_reg(REG_IS_H264, {13'b0, h});
		write_reg(REG_PROFILE, prof);
		write_reg(REG_LEVEL, lvl);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, ht);
	endtask

	task automatic set_idling(int p);
		case (p % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 60; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 60; end
			default: begin send_idle_pct = 34; recv_stall_pct = 34; end
		endcase
	endtask

	initial begin
		update_threshold();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset configuration, threshold four
		add_cmd(OP_DRAIN, 16'h0000, '0, 1'b0, 1'b0);
		add_cmd(OP_FLUSH, 16'hFFFF, '1, 1'b1, 1'b1);
		add_cmd(OP_DECODED, 16'h0000, '0, 1'b1, 1'b1);
		add_cmd(OP_DECODED, 16'hFFFF, '1, 1'b1, 1'b1);
		add_cmd(OP_DECODED, 16'h1234, 63'd500, 1'b0, 1'b1);
		add_cmd(OP_SUBMIT, 16'h0001, '0, 1'b0, 1'b0);
		add_cmd(OP_DECODED, 16'h5555, 63'd100, 1'b1, 1'b1);
		add_cmd(OP_DECODED, 16'hAAAA, 63'd100, 1'b1, 1'b1);
		add_cmd(OP_DECODED, 16'hBEEF, '1, 1'b1, 1'b0);
		add_cmd(OP_DECODED, 16'h0F0F, '0, 1'b0, 1'b0);
		add_cmd(OP_SUBMIT, 16'h0002, '1, 1'b1, 1'b1);
		add_cmd(OP_DECODED, 16'h0003, 63'd7, 1'b1, 1'b1);
		add_cmd(OP_DECODED, 16'h0004, 63'd3, 1'b1, 1'b1);
		add_cmd(OP_DECODED, 16'h0005, 63'd9, 1'b0, 1'b1);
		add_cmd(OP_DRAIN, 16'h0006, '0, 1'b0, 1'b0);
		add_cmd(OP_DECODED, 16'h0007, 63'd1, 1'b1, 1'b1);
		add_cmd(OP_DECODED, 16'h0008, 63'd0, 1'b1, 1'b1);
		add_cmd(OP_FLUSH, 16'h0009, '0, 1'b0, 1'b0);
		add_random(32);
		wait_quiet();

		// ignored register indexes
		for (int k = int'(REG_HEIGHT) + 1; k < 8; k++)
			write_reg(CFG_IDX_W'(k), '1);

		for (int p = 1; p <= 8; p++) begin
			case (p)
				1: set_config(1'b1, 14'd100, 14'd30, 14'd720, 14'd576);
				2: set_config(1'b0, 14'd100, 14'd40, 14'd1920, 14'd1088);
				3: set_config(1'b1, 14'd66, 14'd40, 14'd1920, 14'd1088);
				4: set_config(1'b1, 14'd100, 14'd99, 14'd1920, 14'd1088);
				5: set_config(1'b1, 14'd100, 14'd51, 14'd16, 14'd16);
				6: set_config(1'b1, 14'd255, 14'd0, 14'd0, 14'd1);
				7: set_config(1'b1, 14'h3FFF, 14'd10, 14'h3FFF, 14'd8192);
				default: set_config(1'b1, 14'd0, 14'd52, 14'd1280, 14'd720);
			endcase
			set_idling(p);
			if (p == 5) begin
				// fill the queue past full, then burst out against a stalled receiver
				for (int i = 0; i < 34; i++)
					add_cmd(OP_DECODED, TAG_W'($urandom), rand_pts(), 1'b1, 1'b1);
				add_cmd(OP_SUBMIT, TAG_W'($urandom), '0, 1'b0, 1'b0);
				for (int i = 0; i < 20; i++)
					add_cmd(OP_DECODED, TAG_W'($urandom), rand_pts(), 1'b1, 1'b1);
				add_cmd(OP_DRAIN, 16'h0000, '0, 1'b0, 1'b0);
				hold_go = 1'b1;
			end
			add_random(44);
			wait_quiet();
		end

		$display("covered %0d commands and %0d result words over nine configurations",
			cmds_taken, words_seen);
		$display("with idling, stalls, a full queue and a long output hold-off; %0d errors",
			errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
